>>> src/spimf_pkg.sv
// ----------------------------------------------------------------------------
// SPI master package
// Shared word types, command codes, register indexes and the byte period.
// ----------------------------------------------------------------------------
`default_nettype none

package spimf_pkg;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] CFG_ENABLE    = 2'd0;
	localparam logic [1:0] CFG_CLOCK_SEL = 2'd1;
	localparam logic [1:0] CFG_IRQ_MASK  = 2'd2;

	localparam int CFG_DATA_W = 4;
	localparam int TIMER_W    = 10;

	// Word taken in on the input side.
	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic [7:0] miso_byte;
	} in_item_t;

	// Word delivered on the result side.
	typedef struct packed {
		logic [7:0] read_byte;
		logic [3:0] status_bits;
		logic       interrupt;
		logic [7:0] shift_byte;
		logic       transfer_done;
	} out_item_t;

	// Classified word passed from the front to the back.
	typedef struct packed {
		logic       is_tick;
		logic       is_write;
		logic       is_read;
		logic [7:0] data_byte;
		logic [7:0] miso_byte;
	} op_item_t;

	// Byte period in clock ticks: 16 shifted left by the code, capped at 512.
	function automatic logic [TIMER_W-1:0] period_for(input logic [2:0] code);
		logic [TIMER_W-1:0] p;
		if (code >= 3'd5) begin
			p = TIMER_W'(512);
		end else begin
			p = TIMER_W'(16) << code;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

>>> src/spi_master_with_byte_fifos.sv
// ----------------------------------------------------------------------------
// SPI master with byte FIFOs
// Each input word is a clock tick, a transmit byte write, a receive byte read
// or the unused code, and gives exactly one result word. The block takes one
// word per clock cycle sustained: a two-entry queue holds decoded words, the
// back end carries out one word per cycle, and a two-entry result queue holds
// results until they are popped. A pushed word is registered in both queues
// in turn before it reaches the result ports. Throughput drops only while the
// result queue is full. Configuration writes take effect at the next clock
// edge and should be made while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_master_with_byte_fifos
	import spimf_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  push,
	input  wire in_item_t              item,
	output logic                       full,
	input  wire logic                  pop,
	output out_item_t                  result,
	output logic                       empty
);

	op_item_t  op_item;
	logic      op_empty;
	logic      op_pop;
	logic      res_full;
	logic      res_push;
	out_item_t res_item;

	spimf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.op_pop  (op_pop),
		.op_item (op_item),
		.op_empty(op_empty)
	);

	spimf_back #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.op_item  (op_item),
		.op_empty (op_empty),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_item (res_item)
	);

	spimf_queue #(
		.WIDTH($bits(out_item_t))
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_item),
		.full  (res_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

`default_nettype wire

>>> src/spimf_queue.sv
// ----------------------------------------------------------------------------
// Two-entry word queue
// Small circular queue that decouples a producer from a consumer; a push and
// a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spimf_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

>>> src/spimf_front.sv
// ----------------------------------------------------------------------------
// SPI master front end
// Takes input words, decodes the command and queues the classified word for
// the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spimf_front
	import spimf_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	input  wire logic     op_pop,
	output op_item_t      op_item,
	output logic          op_empty
);

	op_item_t decoded;

	always_comb begin
		decoded           = '0;
		decoded.data_byte = item.data_byte;
		decoded.miso_byte = item.miso_byte;
		case (item.command)
			CMD_TICK:  decoded.is_tick  = 1'b1;
			CMD_WRITE: decoded.is_write = 1'b1;
			CMD_READ:  decoded.is_read  = 1'b1;
			// The unused code carries no operation and only reports state.
			default:   decoded.is_tick  = 1'b0;
		endcase
	end

	spimf_queue #(
		.WIDTH($bits(op_item_t))
	) u_op_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (decoded),
		.full  (full),
		.pop   (op_pop),
		.dout  (op_item),
		.empty (op_empty)
	);

endmodule

`default_nettype wire

>>> src/spimf_back.sv
// ----------------------------------------------------------------------------
// SPI master back end
// Holds the FIFOs, byte timer, shift register, status and configuration, and
// carries out one classified word per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module spimf_back
	import spimf_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire op_item_t              op_item,
	input  wire logic                  op_empty,
	output logic                       op_pop,
	input  wire logic                  res_full,
	output logic                       res_push,
	output out_item_t                  res_item
);

	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
	localparam int IDX_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(FIFO_DEPTH);

	logic               enable_q;
	logic [2:0]         clock_sel_q;
	logic [3:0]         irq_mask_q;

	logic [7:0]         tx_store_q [FIFO_DEPTH];
	logic [7:0]         rx_store_q [FIFO_DEPTH];
	logic [FILL_W-1:0]  tx_fill_q;
	logic [FILL_W-1:0]  rx_fill_q;
	logic [TIMER_W-1:0] timer_q;
	logic [7:0]         shift_q;
	logic [3:0]         status_q;

	logic [FILL_W-1:0]  tx_fill_d;
	logic [FILL_W-1:0]  rx_fill_d;
	logic [TIMER_W-1:0] timer_d;
	logic [TIMER_W-1:0] timer_dec;
	logic [7:0]         shift_d;
	logic [3:0]         status_d;
	logic [FILL_W-1:0]  tx_last;
	logic               tx_push;
	logic               rx_push;
	logic               rx_pop;
	logic               go;

	// An item is carried out only when the result queue has a free entry; a
	// full queue takes no push even while it is being popped.
	assign go       = !op_empty && !res_full;
	assign op_pop   = go;
	assign res_push = go;
	assign tx_last  = tx_fill_q - FILL_W'(1);

	always_comb begin
		tx_fill_d = tx_fill_q;
		rx_fill_d = rx_fill_q;
		timer_d   = timer_q;
		timer_dec = timer_q;
		shift_d   = shift_q;
		status_d  = status_q;
		tx_push   = 1'b0;
		rx_push   = 1'b0;
		rx_pop    = 1'b0;
		res_item  = '0;
		if (go) begin
			if (op_item.is_write) begin
				if (tx_fill_q < DEPTH_F) begin
					tx_push   = 1'b1;
					tx_fill_d = tx_fill_q + FILL_W'(1);
				end
			end else if (op_item.is_read) begin
				res_item.read_byte = rx_store_q[0];
				if (rx_fill_q != '0) begin
					rx_pop    = 1'b1;
					rx_fill_d = rx_fill_q - FILL_W'(1);
				end
			end else if (op_item.is_tick && enable_q) begin
				if (timer_q != '0) begin
					timer_dec = timer_q - TIMER_W'(1);
				end
				timer_d = timer_dec;
				if (timer_q == TIMER_W'(1)) begin
					res_item.transfer_done = 1'b1;
					if (rx_fill_q < DEPTH_F) begin
						rx_push   = 1'b1;
						rx_fill_d = rx_fill_q + FILL_W'(1);
					end
				end
				if (tx_fill_q != '0 && timer_dec == '0) begin
					tx_fill_d = tx_last;
					shift_d   = tx_store_q[tx_last[IDX_W-1:0]];
					timer_d   = period_for(clock_sel_q);
				end
				status_d = {tx_fill_d < DEPTH_F, tx_fill_d == '0,
					rx_fill_d != '0, rx_fill_d >= DEPTH_F};
				res_item.interrupt = |(status_d & ~irq_mask_q);
			end
		end
		res_item.status_bits = status_d;
		res_item.shift_byte  = shift_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			clock_sel_q <= 3'd0;
			irq_mask_q  <= 4'd0;
			tx_fill_q   <= '0;
			rx_fill_q   <= '0;
			timer_q     <= '0;
			shift_q     <= 8'd0;
			status_q    <= 4'd0;
			for (int i = 0; i < FIFO_DEPTH; i++) begin
				rx_store_q[i] <= 8'd0;
			end
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_ENABLE:    enable_q    <= cfg_data[0];
					CFG_CLOCK_SEL: clock_sel_q <= cfg_data[2:0];
					CFG_IRQ_MASK:  irq_mask_q  <= cfg_data[3:0];
					default:       enable_q    <= enable_q;
				endcase
			end
			tx_fill_q <= tx_fill_d;
			rx_fill_q <= rx_fill_d;
			timer_q   <= timer_d;
			shift_q   <= shift_d;
			status_q  <= status_d;
			// The receive head sits in entry 0; a pop moves the rest down and
			// leaves the last entry as it was.
			if (rx_pop) begin
				for (int i = 0; i + 1 < FIFO_DEPTH; i++) begin
					rx_store_q[i] <= rx_store_q[i + 1];
				end
			end else if (rx_push) begin
				rx_store_q[rx_fill_q[IDX_W-1:0]] <= op_item.miso_byte;
			end
		end
	end

	// Transmit entries need no reset: only written entries are ever read.
	always_ff @(posedge clk) begin
		if (tx_push) begin
			for (int i = FIFO_DEPTH - 1; i > 0; i--) begin
				tx_store_q[i] <= tx_store_q[i - 1];
			end
			tx_store_q[0] <= op_item.data_byte;
		end
	end

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI master with byte FIFOs: self-checking testbench
// Drives command words through the push/full side, predicts every result word
// with a cycle-free model of the FIFOs, byte timer and status flags, and checks
// each popped word against the oldest prediction. Directed tests cover the
// idle block, transfers, a slow bus clock and the capped byte period; random
// traffic runs under three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------

module tb;
	import spimf_pkg::*;

	localparam int         QDEPTH      = 2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         ST_RX_FULL  = 0;
	localparam int         ST_RX_READY = 1;
	localparam int         ST_TX_EMPTY = 2;
	localparam int         ST_TX_READY = 3;
	localparam int         MAX_REPORTS = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	in_item_t              item;
	logic                  full;
	logic                  pop;
	out_item_t             result;
	logic                  empty;

	spi_master_with_byte_fifos dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.full      (full),
		.pop       (pop),
		.result    (result),
		.empty     (empty)
	);

	// Predictor state: registers, both byte FIFOs, timer and status.
	logic       en_m;
	logic [2:0] csel_m;
	logic [3:0] mask_m;
	logic [7:0] tx_mem [QDEPTH];
	int         tx_cnt;
	logic [7:0] rx_mem [QDEPTH];
	int         rx_cnt;
	logic [9:0] timer_m;
	logic [7:0] shreg_m;
	logic [3:0] status_m;

	out_item_t  pending_results [$];
	out_item_t  want;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         fail_count;
	int         words_checked;
	int         transfers_seen;
	int         bytes_dropped;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic out_item_t spi_step(input in_item_t w);
		out_item_t r;
		int        i;
		r = '0;
		case (w.command)
			CMD_WRITE: begin
				if (tx_cnt < QDEPTH) begin
					for (i = QDEPTH - 1; i > 0; i--) tx_mem[i] = tx_mem[i - 1];
					tx_mem[0] = w.data_byte;
					tx_cnt++;
				end else begin
					bytes_dropped++;
				end
			end
			CMD_READ: begin
				// An empty queue still returns whatever sits in its head entry.
				r.read_byte = rx_mem[0];
				if (rx_cnt > 0) begin
					for (i = 0; i < QDEPTH - 1; i++) rx_mem[i] = rx_mem[i + 1];
					rx_cnt--;
				end
			end
			CMD_TICK: begin
				if (en_m) begin
					if (timer_m != 0) begin
						timer_m = timer_m - 10'd1;
						if (timer_m == 0) begin
							r.transfer_done = 1'b1;
							transfers_seen++;
							if (rx_cnt < QDEPTH) begin
								rx_mem[rx_cnt] = w.miso_byte;
								rx_cnt++;
							end else begin
								bytes_dropped++;
							end
						end
					end
					if (tx_cnt != 0 && timer_m == 0) begin
						tx_cnt--;
						shreg_m = tx_mem[tx_cnt];
						timer_m = (csel_m >= 3'd5) ? 10'd512 : (10'd16 << csel_m);
					end
					status_m[ST_RX_FULL]  = (rx_cnt >= QDEPTH);
					status_m[ST_RX_READY] = (rx_cnt != 0);
					status_m[ST_TX_EMPTY] = (tx_cnt == 0);
					status_m[ST_TX_READY] = (tx_cnt < QDEPTH);
					r.interrupt = |(status_m & ~mask_m);
				end
			end
			default: begin
			end
		endcase
		r.status_bits = status_m;
		r.shift_byte  = shreg_m;
		return r;
	endfunction

	function automatic in_item_t make_word(input logic [1:0] cmd, input logic [7:0] data,
			input logic [7:0] miso);
		in_item_t w;
		w.command   = cmd;
		w.data_byte = data;
		w.miso_byte = miso;
		return w;
	endfunction

	// Called just after a rising edge. Leaves push high so that a following
	// word can go out back to back.
	task automatic send_word(input in_item_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(posedge clk);
		while (full) @(posedge clk);
		pending_results.push_back(spi_step(w));
	endtask

	task automatic send_ticks(input int n, input logic [7:0] miso);
		int k;
		for (k = 0; k < n; k++) send_word(make_word(CMD_TICK, 8'($urandom), miso));
	endtask

	// Holds the sender off until every predicted word has been popped.
	task automatic wait_all_results();
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic en, input logic [2:0] cs, input logic [3:0] mask);
		wait_all_results();
		set_register(CFG_ENABLE, CFG_DATA_W'(en));
		set_register(CFG_CLOCK_SEL, CFG_DATA_W'(cs));
		set_register(CFG_IRQ_MASK, mask);
		en_m   = en;
		csel_m = cs;
		mask_m = mask;
	endtask

	// Straight after reset the block is disabled: ticks change nothing, reads
	// of the empty receive queue return its stale head and the third write
	// finds the transmit queue full.
	task automatic test_idle_block();
		send_word(make_word(CMD_TICK, 8'hFF, 8'hFF));
		send_word(make_word(CMD_READ, 8'h00, 8'h00));
		send_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF));
		send_word(make_word(CMD_WRITE, 8'hFF, 8'h00));
		send_word(make_word(CMD_WRITE, 8'h00, 8'hFF));
		send_word(make_word(CMD_WRITE, 8'h5A, 8'hA5));
		send_word(make_word(CMD_TICK, 8'h00, 8'h00));
		send_word(make_word(CMD_READ, 8'hFF, 8'hFF));
	endtask

	// Three transfers at the fastest bus clock with no reads, so the last
	// reply byte is lost on a full receive queue; then mask changes and reads.
	task automatic test_transfers();
		configure(1'b1, 3'd0, 4'h0);
		send_word(make_word(CMD_TICK, 8'h00, 8'h00));
		send_word(make_word(CMD_WRITE, 8'h81, 8'h00));
		send_word(make_word(CMD_WRITE, 8'h3C, 8'hFF));
		send_ticks(20, 8'hFF);
		send_word(make_word(CMD_WRITE, 8'hE7, 8'h00));
		send_ticks(20, 8'h00);
		send_ticks(20, 8'($urandom));
		configure(1'b1, 3'd0, 4'hF);
		send_ticks(3, 8'h00);
		configure(1'b1, 3'd0, 4'b0011);
		send_ticks(3, 8'h00);
		send_word(make_word(CMD_READ, 8'h00, 8'h00));
		send_word(make_word(CMD_READ, 8'h00, 8'h00));
		send_word(make_word(CMD_READ, 8'h00, 8'h00));
		send_word(make_word(CMD_UNUSED, 8'h00, 8'h00));
	endtask

	// Slow bus clock: one byte takes 128 ticks.
	task automatic test_slow_clock();
		configure(1'b1, 3'd3, 4'b0101);
		send_word(make_word(CMD_WRITE, 8'($urandom), 8'h00));
		send_ticks(131, 8'($urandom));
		send_word(make_word(CMD_READ, 8'h00, 8'h00));
	endtask

	// The slowest code gives the capped period of 512 ticks, so the second
	// queued byte must stay waiting behind the first for the whole run of
	// ticks. Any transfer still running is finished off first.
	task automatic test_period_cap();
		configure(1'b1, 3'd0, 4'h0);
		while (tx_cnt != 0 || timer_m != 0)
			send_word(make_word(CMD_TICK, 8'h00, 8'($urandom)));
		configure(1'b1, 3'd7, 4'b1010);
		send_word(make_word(CMD_WRITE, 8'($urandom), 8'h00));
		send_word(make_word(CMD_WRITE, 8'($urandom), 8'h00));
		send_ticks(30, 8'($urandom));
	endtask

	task automatic test_random_traffic(input int n_words, input int read_pct);
		in_item_t w;
		int       k;
		int       roll;
		for (k = 0; k < n_words; k++) begin
			if ($urandom_range(39) == 0) wait_all_results();
			roll = $urandom_range(99);
			if (roll < read_pct) w.command = CMD_READ;
			else if (roll < read_pct + 18) w.command = CMD_WRITE;
			else if (roll < read_pct + 20) w.command = CMD_UNUSED;
			else w.command = CMD_TICK;
			w.data_byte = 8'($urandom);
			w.miso_byte = 8'($urandom);
			send_word(w);
		end
	endtask

	task automatic test_random_phases();
		int mode;
		int sub;
		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 69 : 0;
			recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 22 : 0;
			for (sub = 0; sub < 3; sub++) begin
				configure($urandom_range(5) != 0, 3'($urandom_range(2)), 4'($urandom_range(15)));
				// Few reads in the first pass so the receive queue fills up.
				test_random_traffic(15, (sub == 0) ? 2 : 12);
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("tb: result word %h arrived with none expected", result);
				end else begin
					want = pending_results.pop_front();
					words_checked++;
					if (result.read_byte !== want.read_byte ||
							result.status_bits !== want.status_bits ||
							result.interrupt !== want.interrupt ||
							result.shift_byte !== want.shift_byte ||
							result.transfer_done !== want.transfer_done) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("tb: word %0d expected rd=%h st=%h irq=%b sh=%h done=%b",
								words_checked, want.read_byte, want.status_bits,
								want.interrupt, want.shift_byte, want.transfer_done);
							$display("tb: word %0d got      rd=%h st=%h irq=%b sh=%h done=%b",
								words_checked, result.read_byte, result.status_bits,
								result.interrupt, result.shift_byte, result.transfer_done);
						end
					end
				end
			end
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_ENABLE;
		cfg_data  = '0;
		push      = 1'b0;
		item      = '0;
		pop       = 1'b0;
		en_m      = 1'b0;
		csel_m    = '0;
		mask_m    = '0;
		foreach (tx_mem[j]) tx_mem[j] = '0;
		foreach (rx_mem[j]) rx_mem[j] = '0;
		tx_cnt         = 0;
		rx_cnt         = 0;
		timer_m        = '0;
		shreg_m        = '0;
		status_m       = '0;
		fail_count     = 0;
		words_checked  = 0;
		transfers_seen = 0;
		bytes_dropped  = 0;
		send_idle_pct  = 22;
		recv_idle_pct  = 69;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_block();
		test_transfers();
		test_slow_clock();
		test_random_phases();
		test_period_cap();

		wait_all_results();
		repeat (8) @(posedge clk);
		$display("tb: %0d result words checked, %0d byte transfers completed",
			words_checked, transfers_seen);
		$display("tb: %0d bytes dropped on full queues, %0d errors", bytes_dropped, fail_count);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
